FILE: hw/rtl/xlb_pkg.sv
// Shared constants and types for the XOR linear basis block.
package xlb_pkg;

	localparam int unsigned WORD_BITS_DEF = 36;
	localparam int unsigned OPCODE_W      = 3;

	typedef logic [OPCODE_W-1:0] opcode_t;

	localparam opcode_t OP_INSERT = 3'd0;
	localparam opcode_t OP_MEMBER = 3'd1;
	localparam opcode_t OP_MAX    = 3'd2;
	localparam opcode_t OP_MIN    = 3'd3;
	localparam opcode_t OP_CLEAR  = 3'd4;

	typedef struct packed {
		logic accepted;
		logic representable;
		logic dependent_seen;
	} rsp_flags_t;

endpackage

FILE: hw/rtl/xlb_if.sv
// Valid/ready channel interfaces for request and response beats.
interface xlb_in_if #(
	parameter int unsigned WORD_BITS = xlb_pkg::WORD_BITS_DEF
);
	import xlb_pkg::*;

	logic                 valid;
	logic                 ready;
	opcode_t              opcode;
	logic [WORD_BITS-1:0] operand_value;

	modport source (output valid, output opcode, output operand_value, input ready);
	modport sink (input valid, input opcode, input operand_value, output ready);
endinterface

interface xlb_out_if #(
	parameter int unsigned WORD_BITS = xlb_pkg::WORD_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic                 representable;
	logic [WORD_BITS-1:0] result_value;
	logic                 dependent_seen;

	modport source (
		output valid, output accepted, output representable,
		output result_value, output dependent_seen, input ready
	);
	modport sink (
		input valid, input accepted, input representable,
		input result_value, input dependent_seen, output ready
	);
endinterface

FILE: hw/rtl/xor_linear_basis_top.sv
// Top level of the XOR linear basis block: config register, engine, slot memory, output beat.
// One request beat is taken at a time; ready stays low until its response beat is held in the
// output register. Each operation walks the WORD_BITS slots through the single read port of
// the slot memory, one slot per cycle: membership, max, min and echelon-mode insert make one
// pass down the slots (an echelon insert ends at the slot where it lands), a reduced-mode insert
// adds a read-modify-write pass over the slots above its new pivot, and clear or an unused
// opcode goes straight to its response without a walk. Slot occupancy lives in flip-flops, so
// no clearing pass follows reset. A pending response beat does not block the next request.
module xor_linear_basis_top #(
	parameter int unsigned WORD_BITS = xlb_pkg::WORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	xlb_in_if.sink    req,
	xlb_out_if.source rsp
);
	import xlb_pkg::*;

	localparam int unsigned IDX_W = $clog2(WORD_BITS);

	logic                 reduced_mode_q;
	logic                 res_valid;
	logic                 res_ready;
	rsp_flags_t           res_flags;
	logic [WORD_BITS-1:0] res_value;
	logic                 mem_we;
	logic [IDX_W-1:0]     mem_waddr;
	logic [WORD_BITS-1:0] mem_wdata;
	logic [IDX_W-1:0]     mem_raddr;
	logic [WORD_BITS-1:0] mem_rdata;
	logic                 out_vld_q;
	rsp_flags_t           out_flags_q;
	logic [WORD_BITS-1:0] out_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reduced_mode_q <= 1'b0;
		end else if (cfg_we) begin
			reduced_mode_q <= cfg_wdata;
		end
	end

	xlb_engine #(.WORD_BITS(WORD_BITS)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.reduced_mode (reduced_mode_q),
		.in_valid     (req.valid),
		.in_ready     (req.ready),
		.in_opcode    (req.opcode),
		.in_value     (req.operand_value),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_flags    (res_flags),
		.res_value    (res_value),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata)
	);

	xlb_slot_mem #(.WORD_BITS(WORD_BITS)) u_slot_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !out_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_flags_q <= res_flags;
			out_value_q <= res_value;
		end
	end

	assign rsp.valid          = out_vld_q;
	assign rsp.accepted       = out_flags_q.accepted;
	assign rsp.representable  = out_flags_q.representable;
	assign rsp.dependent_seen = out_flags_q.dependent_seen;
	assign rsp.result_value   = out_value_q;

	// engine never offers a result while it can take a request
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !req.ready)
		else $error("result offered while request side ready");

	// an insert cannot also report membership
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_flags.accepted && res_flags.representable))
		else $error("accepted and representable both set");

	// sticky dependency flag never clears
	a_dep_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(res_flags.dependent_seen) |-> res_flags.dependent_seen)
		else $error("dependent flag dropped");

	// a taken request leaves the engine busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("engine ready right after taking a request");
endmodule

FILE: hw/rtl/xlb_slot_mem.sv
// Basis slot storage: one write port, one registered read port.
module xlb_slot_mem #(
	parameter int unsigned WORD_BITS = xlb_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(WORD_BITS)-1:0] waddr,
	input  logic [WORD_BITS-1:0]         wdata,
	input  logic [$clog2(WORD_BITS)-1:0] raddr,
	output logic [WORD_BITS-1:0]         rdata
);
	logic [WORD_BITS-1:0] slot_mem [WORD_BITS];
	logic [WORD_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			slot_mem[waddr] <= wdata;
		end
		rdata_q <= slot_mem[raddr];
	end

	assign rdata = rdata_q;
endmodule

FILE: hw/rtl/xlb_engine.sv
// Slot-walk sequencer and shared XOR datapath for all basis operations.
module xlb_engine #(
	parameter int unsigned WORD_BITS = xlb_pkg::WORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         reduced_mode,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  xlb_pkg::opcode_t             in_opcode,
	input  logic [WORD_BITS-1:0]         in_value,
	output logic                         res_valid,
	input  logic                         res_ready,
	output xlb_pkg::rsp_flags_t          res_flags,
	output logic [WORD_BITS-1:0]         res_value,
	output logic                         mem_we,
	output logic [$clog2(WORD_BITS)-1:0] mem_waddr,
	output logic [WORD_BITS-1:0]         mem_wdata,
	output logic [$clog2(WORD_BITS)-1:0] mem_raddr,
	input  logic [WORD_BITS-1:0]         mem_rdata
);
	import xlb_pkg::*;

	localparam int unsigned IDX_W = $clog2(WORD_BITS);
	localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(WORD_BITS - 1);

	typedef enum logic [1:0] {S_IDLE, S_WALK, S_FIX, S_DONE} state_t;

	state_t               state_q;
	opcode_t              op_q;
	logic [WORD_BITS-1:0] t_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 found_q;
	logic                 fail_q;
	logic                 acc_q;
	logic                 dep_q;
	logic                 wr_new_q;
	logic [WORD_BITS-1:0] vld_q;
	logic [IDX_W-1:0]     issue_idx_q;
	logic                 issue_live_q;
	logic [IDX_W-1:0]     proc_idx_s1;
	logic                 proc_vld_s1;

	logic                 cur_bit;
	logic                 cur_vld;
	logic                 new_slot;
	logic [IDX_W-1:0]     pos_now;
	logic [WORD_BITS-1:0] t_nxt;

	assign cur_bit  = t_q[proc_idx_s1];
	assign cur_vld  = vld_q[proc_idx_s1];
	assign new_slot = (state_q == S_WALK) && proc_vld_s1 && (op_q == OP_INSERT) &&
		!found_q && cur_bit && !cur_vld;
	assign pos_now  = found_q ? pos_q : proc_idx_s1;

	always_comb begin
		t_nxt = t_q;
		case (op_q)
			OP_INSERT, OP_MEMBER: begin
				if (cur_bit && cur_vld) begin
					t_nxt = t_q ^ mem_rdata;
				end
			end
			OP_MAX: begin
				// slot i leads with bit i, so XOR raises r exactly when r[i] is clear
				if (cur_vld && !cur_bit) begin
					t_nxt = t_q ^ mem_rdata;
				end
			end
			OP_MIN: begin
				if (cur_vld) begin
					t_nxt = mem_rdata;
				end
			end
			default: t_nxt = t_q;
		endcase
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = proc_idx_s1;
		mem_wdata = t_q;
		if (new_slot && !reduced_mode) begin
			mem_we = 1'b1;
		end else if (state_q == S_FIX) begin
			if (wr_new_q) begin
				mem_we    = 1'b1;
				mem_waddr = pos_q;
			end else if (proc_vld_s1 && cur_vld && mem_rdata[pos_q]) begin
				mem_we    = 1'b1;
				mem_wdata = mem_rdata ^ t_q;
			end
		end
	end

	assign mem_raddr = issue_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INSERT;
			found_q      <= 1'b0;
			fail_q       <= 1'b0;
			acc_q        <= 1'b0;
			dep_q        <= 1'b0;
			wr_new_q     <= 1'b0;
			vld_q        <= '0;
			issue_idx_q  <= '0;
			issue_live_q <= 1'b0;
			proc_idx_s1  <= '0;
			proc_vld_s1  <= 1'b0;
			pos_q        <= '0;
			t_q          <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q         <= in_opcode;
						t_q          <= (in_opcode == OP_INSERT || in_opcode == OP_MEMBER) ?
							in_value : '0;
						found_q      <= 1'b0;
						fail_q       <= 1'b0;
						acc_q        <= 1'b0;
						wr_new_q     <= 1'b0;
						issue_idx_q  <= IDX_TOP;
						issue_live_q <= 1'b1;
						proc_vld_s1  <= 1'b0;
						case (in_opcode)
							OP_INSERT, OP_MEMBER, OP_MAX, OP_MIN: begin
								state_q <= S_WALK;
							end
							OP_CLEAR: begin
								vld_q   <= '0;
								state_q <= S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_WALK: begin
					proc_vld_s1 <= issue_live_q;
					proc_idx_s1 <= issue_idx_q;
					if (issue_live_q) begin
						if (issue_idx_q == '0) begin
							issue_live_q <= 1'b0;
						end else begin
							issue_idx_q <= issue_idx_q - IDX_W'(1);
						end
					end
					if (proc_vld_s1) begin
						t_q <= t_nxt;
						if (op_q == OP_MEMBER && cur_bit && !cur_vld) begin
							fail_q <= 1'b1;
						end
						if (new_slot) begin
							found_q <= 1'b1;
							pos_q   <= proc_idx_s1;
						end
						if (new_slot && !reduced_mode) begin
							vld_q[proc_idx_s1] <= 1'b1;
							acc_q              <= 1'b1;
							state_q            <= S_DONE;
						end else if (proc_idx_s1 == '0) begin
							if (op_q == OP_INSERT) begin
								if (found_q || new_slot) begin
									// back-substitute the new pivot into higher slots
									acc_q        <= 1'b1;
									wr_new_q     <= 1'b1;
									issue_idx_q  <= pos_now + IDX_W'(1);
									issue_live_q <= (pos_now != IDX_TOP);
									proc_vld_s1  <= 1'b0;
									state_q      <= S_FIX;
								end else begin
									dep_q   <= 1'b1;
									state_q <= S_DONE;
								end
							end else begin
								state_q <= S_DONE;
							end
						end
					end
				end
				S_FIX: begin
					proc_vld_s1 <= issue_live_q;
					proc_idx_s1 <= issue_idx_q;
					if (issue_live_q) begin
						if (issue_idx_q == IDX_TOP) begin
							issue_live_q <= 1'b0;
						end else begin
							issue_idx_q <= issue_idx_q + IDX_W'(1);
						end
					end
					if (wr_new_q) begin
						wr_new_q     <= 1'b0;
						vld_q[pos_q] <= 1'b1;
						if (pos_q == IDX_TOP) begin
							state_q <= S_DONE;
						end
					end
					if (proc_vld_s1 && proc_idx_s1 == IDX_TOP) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res_flags.accepted       = acc_q;
	assign res_flags.representable  = (op_q == OP_MEMBER) && !fail_q;
	assign res_flags.dependent_seen = dep_q;
	assign res_value = (op_q == OP_MAX || op_q == OP_MIN) ? t_q : '0;
endmodule

FILE: test/xor_linear_basis_checker.sv
// Checker for the XOR linear basis block: watches both channels, predicts and compares beats.
module xor_linear_basis_checker #(
	parameter int unsigned WB = xlb_pkg::WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	xlb_in_if           req,
	xlb_out_if          rsp,
	output int unsigned pending,
	output int unsigned errors
);
	import xlb_pkg::*;

	typedef logic [WB-1:0] word_t;

	typedef struct packed {
		logic  accepted;
		logic  representable;
		word_t result_value;
		logic  dependent_seen;
	} outcome_t;

	word_t    basis_word [WB];
	logic     sticky_dep;
	logic     reduced;
	outcome_t outcome_q [$];

	function automatic logic span_has(word_t v);
		word_t t;
		logic  ok;
		t  = v;
		ok = 1'b1;
		for (int i = WB - 1; i >= 0; i--) begin
			if (t[i]) begin
				if (basis_word[i] == '0)
					ok = 1'b0;
				t ^= basis_word[i];
			end
		end
		return ok;
	endfunction

	function automatic word_t max_span();
		word_t r;
		r = '0;
		for (int i = WB - 1; i >= 0; i--)
			if ((r ^ basis_word[i]) > r)
				r ^= basis_word[i];
		return r;
	endfunction

	function automatic word_t min_basis();
		word_t r;
		r = '0;
		for (int i = WB - 1; i >= 0; i--)
			if (basis_word[i] != '0)
				r = basis_word[i];
		return r;
	endfunction

	task automatic insert_word(input word_t v, output logic stored);
		word_t t;
		t      = v;
		stored = 1'b0;
		for (int i = WB - 1; i >= 0; i--) begin
			if (!stored && t[i]) begin
				if (basis_word[i] != '0) begin
					t ^= basis_word[i];
				end else begin
					basis_word[i] = t;
					stored        = 1'b1;
					if (reduced) begin
						for (int j = i - 1; j >= 0; j--)
							if (basis_word[j] != '0 && basis_word[i][j])
								basis_word[i] ^= basis_word[j];
						for (int j = i + 1; j < WB; j++)
							if (basis_word[j][i])
								basis_word[j] ^= basis_word[i];
					end
				end
			end
		end
		if (!stored)
			sticky_dep = 1'b1;
	endtask

	task automatic predict_beat(input opcode_t op, input word_t v);
		outcome_t o;
		logic     stored;
		o = '0;
		case (op)
		OP_INSERT: begin
			insert_word(v, stored);
			o.accepted = stored;
		end
		OP_MEMBER: o.representable = span_has(v);
		OP_MAX:    o.result_value  = max_span();
		OP_MIN:    o.result_value  = min_basis();
		OP_CLEAR: begin
			for (int i = 0; i < WB; i++)
				basis_word[i] = '0;
		end
		default: ;
		endcase
		o.dependent_seen = sticky_dep;
		outcome_q.push_back(o);
	endtask

	task automatic check_beat();
		outcome_t e;
		if (outcome_q.size() == 0) begin
			errors++;
			$error("response beat with no request outstanding");
		end else begin
			e = outcome_q.pop_front();
			if (rsp.accepted !== e.accepted) begin
				errors++;
				$error("accepted: expected %0d, got %0d", e.accepted, rsp.accepted);
			end
			if (rsp.representable !== e.representable) begin
				errors++;
				$error("representable: expected %0d, got %0d", e.representable,
					rsp.representable);
			end
			if (rsp.result_value !== e.result_value) begin
				errors++;
				$error("result_value: expected %h, got %h", e.result_value, rsp.result_value);
			end
			if (rsp.dependent_seen !== e.dependent_seen) begin
				errors++;
				$error("dependent_seen: expected %0d, got %0d", e.dependent_seen,
					rsp.dependent_seen);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WB; i++)
				basis_word[i] = '0;
			sticky_dep = 1'b0;
			reduced    = 1'b0;
			errors     = 0;
			outcome_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				reduced = cfg_wdata;
			if (rsp.valid && rsp.ready)
				check_beat();
			if (req.valid && req.ready)
				predict_beat(req.opcode, req.operand_value);
			pending <= outcome_q.size();
		end
	end

endmodule

FILE: test/xor_linear_basis_top_tb.sv
// Testbench top for the XOR linear basis block: clock, reset, stimulus and verdict.
module xor_linear_basis_top_tb;
	import xlb_pkg::*;

	localparam int unsigned WB        = WORD_BITS_DEF;
	localparam int unsigned ITEMS     = 1000;
	localparam int unsigned LIMIT     = 1000000;
	localparam int unsigned LONG_HOLD = 400;

	localparam opcode_t OP_UNUSED_5 = 3'd5;
	localparam opcode_t OP_UNUSED_6 = 3'd6;
	localparam opcode_t OP_UNUSED_7 = 3'd7;

	localparam logic MODE_ECHELON = 1'b0;
	localparam logic MODE_REDUCED = 1'b1;

	typedef logic [WB-1:0] word_t;

	localparam word_t ALL_ONES = {WB{1'b1}};
	localparam word_t TOP_BIT  = word_t'(1) << (WB - 1);

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	int unsigned pending;
	int unsigned errors;

	int unsigned cycles;
	int unsigned n_items;
	int unsigned op_count [8];
	int unsigned n_mode_writes;
	int unsigned n_long_holds;
	int unsigned n_drains;
	int unsigned gap_pct;
	int unsigned stall_pct;
	logic        quiet;
	logic        long_hold_pending;

	word_t       pool_word [40];
	int unsigned pool_n;

	xlb_in_if  #(.WORD_BITS(WB)) req_if ();
	xlb_out_if #(.WORD_BITS(WB)) rsp_if ();

	xor_linear_basis_top #(.WORD_BITS(WB)) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	xor_linear_basis_checker #(.WB(WB)) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if),
		.pending   (pending),
		.errors    (errors)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic word_t rand_word();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[WB-1:0];
	endfunction

	// mostly XOR combinations of a small generator set, so dependent words are common
	function automatic word_t pick_value();
		word_t v;
		v = '0;
		case ($urandom_range(0, 9))
		0: v = rand_word();
		1: begin
			case ($urandom_range(0, 3))
			0: v = '0;
			1: v = ALL_ONES;
			2: v = word_t'(1) << $urandom_range(0, WB - 1);
			default: v = ~(word_t'(1) << $urandom_range(0, WB - 1));
			endcase
		end
		default: begin
			for (int i = 0; i < pool_n; i++)
				if ($urandom_range(0, 1))
					v ^= pool_word[i];
		end
		endcase
		return v;
	endfunction

	task automatic send_beat(input opcode_t op, input word_t v);
		if (!quiet && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.opcode        <= op;
		req_if.operand_value <= v;
		do @(posedge clk); while (!req_if.ready);
		op_count[op]++;
		if (op <= OP_CLEAR)
			n_items++;
	endtask

	task automatic drain();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		n_drains++;
	endtask

	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		n_mode_writes++;
	endtask

	// response side: random stalls, plus one long hold on request
	initial begin
		rsp_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				rsp_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!quiet && stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				rsp_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				rsp_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned span;
		int unsigned clear_pct;
		int unsigned r;
		int unsigned w;
		opcode_t     op;

		cycles            = 0;
		n_items           = 0;
		n_mode_writes     = 0;
		n_long_holds      = 0;
		n_drains          = 0;
		gap_pct           = 0;
		stall_pct         = 0;
		quiet             = 1'b0;
		long_hold_pending = 1'b0;
		pool_n            = 0;
		foreach (op_count[i])
			op_count[i] = 0;
		arst_n               = 1'b0;
		cfg_we               <= 1'b0;
		cfg_wdata            <= MODE_ECHELON;
		req_if.valid         <= 1'b0;
		req_if.opcode        <= OP_INSERT;
		req_if.operand_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty basis, zero insert, extremes, spare opcodes, clear, mode change
		send_beat(OP_MIN, rand_word());
		send_beat(OP_MAX, rand_word());
		send_beat(OP_MEMBER, '0);
		send_beat(OP_INSERT, '0);
		send_beat(OP_INSERT, ALL_ONES);
		send_beat(OP_INSERT, word_t'(1));
		send_beat(OP_INSERT, TOP_BIT);
		send_beat(OP_INSERT, ALL_ONES);
		send_beat(OP_MEMBER, ALL_ONES ^ word_t'(1));
		send_beat(OP_MEMBER, word_t'(2));
		send_beat(OP_MAX, rand_word());
		send_beat(OP_MIN, rand_word());
		send_beat(OP_UNUSED_5, ALL_ONES);
		send_beat(OP_UNUSED_6, rand_word());
		send_beat(OP_UNUSED_7, ALL_ONES);
		send_beat(OP_CLEAR, ALL_ONES);
		send_beat(OP_MIN, rand_word());
		drain();
		write_mode(MODE_REDUCED);
		send_beat(OP_INSERT, word_t'(3));
		send_beat(OP_INSERT, word_t'(1));
		send_beat(OP_INSERT, word_t'(2));
		send_beat(OP_INSERT, ALL_ONES);
		send_beat(OP_MAX, '0);
		send_beat(OP_MIN, '0);
		drain();
		write_mode(MODE_ECHELON);
		send_beat(OP_INSERT, TOP_BIT | word_t'(6));
		send_beat(OP_MEMBER, ALL_ONES);

		phase = 0;
		while (n_items < ITEMS) begin
			if (!quiet) begin
				drain();
				if (phase == 0 || $urandom_range(0, 9) < 7)
					write_mode(logic'($urandom_range(0, 1)));
			end
			pool_n = $urandom_range(1, 40);
			for (int i = 0; i < pool_n; i++) begin
				w = $urandom_range(1, WB);
				pool_word[i] = rand_word() & (ALL_ONES >> (WB - w));
			end
			case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 8;
			default: gap_pct = 30;
			endcase
			case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 8;
			default: stall_pct = 30;
			endcase
			clear_pct = (pool_n > 30) ? 0 : 3;
			if (phase == 2 || phase == 9) begin
				gap_pct           = 0;
				long_hold_pending = 1'b1;
				n_long_holds++;
			end
			span = $urandom_range(20, 80);
			repeat (span) begin
				if (n_items + 150 >= ITEMS)
					quiet = 1'b1;
				r = $urandom_range(0, 99);
				if (r < 55)
					op = OP_INSERT;
				else if (r < 75)
					op = OP_MEMBER;
				else if (r < 84)
					op = OP_MAX;
				else if (r < 93)
					op = OP_MIN;
				else if (r < 93 + clear_pct)
					op = OP_CLEAR;
				else if (r < 97)
					op = OP_INSERT;
				else begin
					case ($urandom_range(0, 2))
					0: op = OP_UNUSED_5;
					1: op = OP_UNUSED_6;
					default: op = OP_UNUSED_7;
					endcase
				end
				send_beat(op, pick_value());
			end
			phase++;
		end

		drain();
		repeat (2 * WB + 8) @(posedge clk);

		$display("covered %0d beats: %0d inserts, %0d membership, %0d max, %0d min,",
			n_items, op_count[OP_INSERT], op_count[OP_MEMBER], op_count[OP_MAX],
			op_count[OP_MIN]);
		$display("  %0d clears, %0d spare; mode written %0d times, %0d long holds, %0d drains",
			op_count[OP_CLEAR],
			op_count[OP_UNUSED_5] + op_count[OP_UNUSED_6] + op_count[OP_UNUSED_7],
			n_mode_writes, n_long_holds, n_drains);
		if (errors == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
